[hdl/nmeac_pkg.sv]
package nmeac_pkg;

    // Fields of one input beat: a sentence byte and its end marker.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } in_t;

    // Fields of one result beat.
    typedef struct packed {
        logic [1:0]  status;
        logic        check_ok;
        logic [7:0]  computed_sum;
        logic [15:0] sentence_hash;
    } out_t;

    // Configuration register contents.
    typedef struct packed {
        logic        sum_strict;
        logic        len_strict;
        logic [7:0]  max_length;
        logic [15:0] gga_code;
    } cfg_t;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_SUM_STRICT = 2'd0,
        REG_LEN_STRICT = 2'd1,
        REG_MAX_LENGTH = 2'd2,
        REG_GGA_CODE   = 2'd3
    } reg_idx_t;

    // Parser phase within one sentence.
    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_BODY  = 3'd1,
        PH_HEX1  = 3'd2,
        PH_HEX2  = 3'd3,
        PH_TAIL  = 3'd4,
        PH_ENDED = 3'd5
    } phase_t;

    localparam logic [1:0] ST_INVALID = 2'd0;
    localparam logic [1:0] ST_GGA     = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    localparam logic [15:0] HASH_SEED  = 16'd5381;
    localparam logic [7:0]  CH_DOLLAR  = 8'h24;
    localparam logic [7:0]  CH_STAR    = 8'h2A;
    localparam logic [7:0]  COUNT_MAX  = 8'd255;
    localparam logic [8:0]  LEN_SLACK  = 9'd3;

    localparam logic [15:0] RST_GGA_CODE   = 16'd59988;
    localparam logic [7:0]  RST_MAX_LENGTH = 8'd82;

    // Hex digit value in the low four bits; bit 4 set means not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        if (c inside {[8'h30:8'h39]}) begin
            v = {1'b0, c[3:0]};
        end
        else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            v = {1'b0, c[3:0] + 4'd9};
        end
        else begin
            v = 5'b10000;
        end
        return v;
    endfunction

endpackage

[hdl/nmea_sentence_checker_unit.sv]
// A result beat is registered: the last byte of a sentence passes the input
// register, then the result register, before its result reaches the output.
// Throughput: one byte per cycle; the per-byte state update is a single
// pass of logic. A last byte waits only while an untaken result is held.
// Reset: asynchronous, active low; parser returns to waiting for '$'.
// Configuration registers return to their documented defaults.
module nmea_sentence_checker_unit
    import nmeac_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_t        out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Input register: holds one accepted beat until the parser consumes it.
    logic in_vld_reg;
    in_t  in_reg;

    // Result register: holds one finished result until it is taken.
    logic out_vld_reg;
    out_t out_reg;

    cfg_t cfg;
    out_t res;
    logic fire;

    nmeac_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The held byte is consumed whenever it produces no result, or when
    // the result register is empty or being emptied in this cycle.
    assign fire = in_vld_reg && (!in_reg.last || !out_vld_reg || out_ready);

    // A new beat can enter whenever the input register drains this cycle.
    assign in_ready = !in_vld_reg || fire;

    nmeac_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_reg),
        .cfg   (cfg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_vld_reg <= 1'b0;
        end
        else if (in_valid && in_ready) begin
            in_vld_reg <= 1'b1;
        end
        else if (fire) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (in_valid && in_ready) begin
            in_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_vld_reg <= 1'b0;
        end
        else if (fire && in_reg.last) begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (fire && in_reg.last) begin
            out_reg <= res;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    // A stalled result must never be overwritten by a new one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_ready) |-> !(fire && in_reg.last))
        else $error("result register overwritten while stalled");

    // Consuming a last byte always produces a result beat next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_reg.last) |=> out_vld_reg)
        else $error("last byte consumed without a result");

    // A passing check can never be reported as invalid.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_reg.check_ok) |-> (out_reg.status != ST_INVALID))
        else $error("passing sentence reported invalid");

endmodule

[hdl/nmeac_regs.sv]
module nmeac_regs
    import nmeac_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg.sum_strict <= 1'b1;
            cfg_reg.len_strict <= 1'b0;
            cfg_reg.max_length <= RST_MAX_LENGTH;
            cfg_reg.gga_code   <= RST_GGA_CODE;
        end
        else if (wr_en) begin
            case (idx)
                REG_SUM_STRICT: cfg_reg.sum_strict <= pwdata[0];
                REG_LEN_STRICT: cfg_reg.len_strict <= pwdata[0];
                REG_MAX_LENGTH: cfg_reg.max_length <= pwdata[7:0];
                REG_GGA_CODE:   cfg_reg.gga_code   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_SUM_STRICT: prdata = {31'd0, cfg_reg.sum_strict};
            REG_LEN_STRICT: prdata = {31'd0, cfg_reg.len_strict};
            REG_MAX_LENGTH: prdata = {24'd0, cfg_reg.max_length};
            REG_GGA_CODE:   prdata = {16'd0, cfg_reg.gga_code};
            default:        prdata = 32'd0;
        endcase
    end

endmodule

[hdl/nmeac_parser.sv]
module nmeac_parser
    import nmeac_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic fire,
    input  in_t  item,
    input  cfg_t cfg,
    output out_t res
);

    phase_t      phase_reg,  phase_next,  phase_upd;
    logic [7:0]  xor_reg,    xor_next,    xor_upd;
    logic [3:0]  hi_reg,     hi_next,     hi_upd;
    logic [7:0]  count_reg,  count_next,  count_upd;
    logic [15:0] hash_reg,   hash_next,   hash_upd;
    logic        ferr_reg,   ferr_next,   ferr_upd;
    logic        match_reg,  match_next,  match_upd;
    logic [4:0]  hx;
    logic [3:0]  nib;
    logic        ok;
    logic        too_long;

    assign hx  = hex_value(item.ch);
    assign nib = hx[4] ? 4'd0 : hx[3:0];

    always_comb begin
        phase_upd = phase_reg;
        xor_upd   = xor_reg;
        hi_upd    = hi_reg;
        count_upd = count_reg;
        hash_upd  = hash_reg;
        ferr_upd  = ferr_reg;
        match_upd = match_reg;

        if (phase_reg != PH_ENDED) begin
            if (item.ch == 8'd0) begin
                // A zero byte ends the text; it is a format error unless
                // both hex digits have already arrived.
                if (phase_reg != PH_TAIL) begin
                    ferr_upd = 1'b1;
                end
                phase_upd = PH_ENDED;
            end
            else begin
                if (count_reg inside {[8'd3:8'd5]}) begin
                    hash_upd = (hash_reg << 5) + hash_reg + {8'd0, item.ch};
                end
                if (count_reg != COUNT_MAX) begin
                    count_upd = count_reg + 8'd1;
                end
                case (phase_reg)
                    PH_START: begin
                        if (item.ch != CH_DOLLAR) begin
                            ferr_upd = 1'b1;
                        end
                        phase_upd = PH_BODY;
                    end
                    PH_BODY: begin
                        if (item.ch == CH_STAR) begin
                            phase_upd = PH_HEX1;
                        end
                        else begin
                            xor_upd = xor_reg ^ item.ch;
                        end
                    end
                    PH_HEX1: begin
                        if (hx[4]) begin
                            ferr_upd = 1'b1;
                        end
                        hi_upd    = nib;
                        phase_upd = PH_HEX2;
                    end
                    PH_HEX2: begin
                        if (hx[4]) begin
                            ferr_upd = 1'b1;
                        end
                        match_upd = ({hi_reg, nib} == xor_reg);
                        phase_upd = PH_TAIL;
                    end
                    default: ;
                endcase
            end
        end

        too_long = cfg.len_strict &&
                   ({1'b0, count_upd} > ({1'b0, cfg.max_length} + LEN_SLACK));
        ok = !ferr_upd && match_upd && !too_long;

        res.check_ok      = ok;
        res.computed_sum  = xor_upd;
        res.sentence_hash = hash_upd;
        if (!ok && cfg.sum_strict) begin
            res.status = ST_INVALID;
        end
        else if (hash_upd == cfg.gga_code) begin
            res.status = ST_GGA;
        end
        else begin
            res.status = ST_UNKNOWN;
        end

        phase_next = phase_reg;
        xor_next   = xor_reg;
        hi_next    = hi_reg;
        count_next = count_reg;
        hash_next  = hash_reg;
        ferr_next  = ferr_reg;
        match_next = match_reg;
        if (fire) begin
            if (item.last) begin
                phase_next = PH_START;
                xor_next   = 8'd0;
                hi_next    = 4'd0;
                count_next = 8'd0;
                hash_next  = HASH_SEED;
                ferr_next  = 1'b0;
                match_next = 1'b0;
            end
            else begin
                phase_next = phase_upd;
                xor_next   = xor_upd;
                hi_next    = hi_upd;
                count_next = count_upd;
                hash_next  = hash_upd;
                ferr_next  = ferr_upd;
                match_next = match_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg <= PH_START;
            xor_reg   <= 8'd0;
            hi_reg    <= 4'd0;
            count_reg <= 8'd0;
            hash_reg  <= HASH_SEED;
            ferr_reg  <= 1'b0;
            match_reg <= 1'b0;
        end
        else begin
            phase_reg <= phase_next;
            xor_reg   <= xor_next;
            hi_reg    <= hi_next;
            count_reg <= count_next;
            hash_reg  <= hash_next;
            ferr_reg  <= ferr_next;
            match_reg <= match_next;
        end
    end

endmodule
